// ===== src/sorted_block_request_queue_unit_defines.svh =====
// -----------------------------------------------------------------------------
// Sorted block request queue: assertion macros
// Shared concurrent assertion forms for the checker.
// -----------------------------------------------------------------------------
`ifndef SORTED_BLOCK_REQUEST_QUEUE_UNIT_DEFINES_SVH
`define SORTED_BLOCK_REQUEST_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication
`define SBRQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SBRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/sbrq_pkg.sv =====
// -----------------------------------------------------------------------------
// Sorted block request queue package
// Sizes, codes and word types shared by the queue modules.
// -----------------------------------------------------------------------------
package sbrq_pkg;

   localparam int SLOTS  = 32;
   localparam int SLOT_W = 5;
   localparam int CNT_W  = 6;

   localparam logic [7:0] MERGE_LIMIT_RESET = 8'd10;

   localparam logic [2:0] KIND_APPEND = 3'd0;
   localparam logic [2:0] KIND_INSERT = 3'd1;
   localparam logic [2:0] KIND_FIND   = 3'd2;
   localparam logic [2:0] KIND_MERGE  = 3'd3;
   localparam logic [2:0] KIND_REMOVE = 3'd4;
   localparam logic [2:0] KIND_NEXT   = 3'd5;
   localparam logic [2:0] KIND_UPDATE = 3'd6;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_NONE = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]        kind;
      logic [30:0]       block_number;
      logic [7:0]        op_code;
      logic [7:0]        merge_count_in;
      logic [SLOT_W-1:0] slot_in;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot_out;
      logic [30:0]       found_block;
      logic [7:0]        found_op;
      logic [7:0]        found_merge_count;
      logic              is_empty;
      logic [CNT_W-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [30:0] blk;
      logic [7:0]  op;
      logic [7:0]  merges;
   } entry_type;

   typedef struct packed {
      logic [SLOT_W-1:0] nxt;
      logic [SLOT_W-1:0] prv;
   } link_type;

   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic [SLOT_W-1:0] wr_addr;
      entry_type         wr_entry;
      logic              wr_entry_en;
      logic              wr_merges_en;
      link_type          wr_link;
      logic              wr_next_en;
      logic              wr_prev_en;
   } mem_req_type;

endpackage

// ===== src/sbrq_store.sv =====
// -----------------------------------------------------------------------------
// Sorted block request queue: entry store
// Entry data and link memories, one write address and one registered read.
// -----------------------------------------------------------------------------
module sbrq_store (
   input  logic                 clock,
   input  sbrq_pkg::mem_req_type mem_req,
   output sbrq_pkg::entry_type  rd_entry,
   output sbrq_pkg::link_type   rd_link
);

   sbrq_pkg::entry_type data_mem [sbrq_pkg::SLOTS];
   sbrq_pkg::link_type  link_mem [sbrq_pkg::SLOTS];
   sbrq_pkg::entry_type rd_entry_ff;
   sbrq_pkg::link_type  rd_link_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_entry_en) begin
         data_mem[mem_req.wr_addr] <= mem_req.wr_entry;
      end else if (mem_req.wr_merges_en) begin
         data_mem[mem_req.wr_addr].merges <= mem_req.wr_entry.merges;
      end
      if (mem_req.wr_next_en) begin
         link_mem[mem_req.wr_addr].nxt <= mem_req.wr_link.nxt;
      end
      if (mem_req.wr_prev_en) begin
         link_mem[mem_req.wr_addr].prv <= mem_req.wr_link.prv;
      end
      if (mem_req.rd_en) begin
         rd_entry_ff <= data_mem[mem_req.rd_addr];
         rd_link_ff  <= link_mem[mem_req.rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_link  = rd_link_ff;

endmodule

// ===== src/sbrq_ctrl.sv =====
// -----------------------------------------------------------------------------
// Sorted block request queue: sequencer
// Walks the linked order through the store, one entry read per cycle.
// -----------------------------------------------------------------------------
module sbrq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sbrq_pkg::req_type     req_data,
   input  logic [7:0]            merge_limit,
   output logic                  res_valid,
   input  logic                  res_ready,
   output sbrq_pkg::rsp_type     res_data,
   output sbrq_pkg::mem_req_type mem_req,
   input  sbrq_pkg::entry_type   rd_entry,
   input  sbrq_pkg::link_type    rd_link
);

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_INS_HEAD, S_HEAD_PREV, S_INS_TAIL, S_LINK_TAIL,
      S_INS_WALK, S_INS_LU, S_INS_LV, S_FIND, S_MRG_TAIL, S_MRG_HEAD,
      S_MRG_WALK, S_RM_CHK, S_RM_W2, S_NX_LINK, S_NX_DATA, S_UPD, S_RESP
   } state_type;

   localparam logic [sbrq_pkg::CNT_W-1:0] SLOTS_CNT = sbrq_pkg::CNT_W'(sbrq_pkg::SLOTS);

   state_type                     state_ff;
   sbrq_pkg::req_type             item_ff;
   logic [sbrq_pkg::SLOTS-1:0]    used_ff;
   logic [sbrq_pkg::SLOT_W-1:0]   head_ff, tail_ff, p_ff, u_ff, unext_ff;
   logic [sbrq_pkg::CNT_W-1:0]    count_ff, n_ff;
   sbrq_pkg::entry_type           ue_ff;
   sbrq_pkg::link_type            lnk_ff;
   sbrq_pkg::rsp_type             res_ff;

   logic [sbrq_pkg::SLOT_W-1:0]   free_slot;
   logic                          full;
   logic [sbrq_pkg::SLOT_W-1:0]   sl;
   logic                          sl_ok;
   logic [30:0]                   blk;
   sbrq_pkg::entry_type           item_entry;
   logic [sbrq_pkg::CNT_W-1:0]    n_inc;
   logic                          walk_go, ins_hit, mrg_key, key_hit, mrg_ok;

   function automatic sbrq_pkg::rsp_type res_ok(logic [sbrq_pkg::SLOT_W-1:0] s,
                                                sbrq_pkg::entry_type e);
      sbrq_pkg::rsp_type r;
      r                   = '0;
      r.status            = sbrq_pkg::STAT_OK;
      r.slot_out          = s;
      r.found_block       = e.blk;
      r.found_op          = e.op;
      r.found_merge_count = e.merges;
      return r;
   endfunction

   function automatic sbrq_pkg::rsp_type res_bad(logic [1:0] st);
      sbrq_pkg::rsp_type r;
      r        = '0;
      r.status = st;
      return r;
   endfunction

   // lowest free slot
   always_comb begin
      free_slot = '0;
      for (int i = sbrq_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_slot = sbrq_pkg::SLOT_W'(i);
         end
      end
   end

   assign full       = &used_ff;
   assign sl         = item_ff.slot_in;
   assign sl_ok      = used_ff[sl];
   assign blk        = item_ff.block_number;
   assign item_entry = '{blk: blk, op: item_ff.op_code, merges: item_ff.merge_count_in};
   assign n_inc      = n_ff + 1'b1;
   assign walk_go    = (unext_ff != tail_ff) && (n_inc < SLOTS_CNT);
   assign ins_hit    = (ue_ff.blk <= blk) && (blk < rd_entry.blk);
   assign mrg_key    = (ue_ff.blk == blk) && (blk < rd_entry.blk);
   assign key_hit    = (rd_entry.blk == blk) && (rd_entry.op == item_ff.op_code);
   assign mrg_ok     = (ue_ff.op == item_ff.op_code) && (ue_ff.merges < merge_limit);

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_RESP);

   always_comb begin
      res_data             = res_ff;
      res_data.is_empty    = (count_ff == '0);
      res_data.entry_count = count_ff;
   end

   // store requests
   always_comb begin
      mem_req = '0;
      unique case (state_ff)
         S_DISPATCH: begin
            unique case (item_ff.kind)
               sbrq_pkg::KIND_APPEND, sbrq_pkg::KIND_INSERT: begin
                  if (!full) begin
                     if (count_ff == '0) begin
                        mem_req.wr_addr     = p_ff;
                        mem_req.wr_entry    = item_entry;
                        mem_req.wr_entry_en = 1'b1;
                     end else if (item_ff.kind == sbrq_pkg::KIND_INSERT) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = head_ff;
                     end else begin
                        mem_req.wr_addr     = p_ff;
                        mem_req.wr_entry    = item_entry;
                        mem_req.wr_entry_en = 1'b1;
                        mem_req.wr_link.prv = tail_ff;
                        mem_req.wr_prev_en  = 1'b1;
                     end
                  end
               end
               sbrq_pkg::KIND_FIND: begin
                  mem_req.rd_en   = (count_ff != '0);
                  mem_req.rd_addr = head_ff;
               end
               sbrq_pkg::KIND_MERGE: begin
                  mem_req.rd_en   = (count_ff != '0);
                  mem_req.rd_addr = tail_ff;
               end
               sbrq_pkg::KIND_REMOVE, sbrq_pkg::KIND_UPDATE: begin
                  mem_req.rd_en   = sl_ok;
                  mem_req.rd_addr = sl;
               end
               sbrq_pkg::KIND_NEXT: begin
                  mem_req.rd_en   = sl_ok && ((sl != tail_ff) || (sl != head_ff));
                  mem_req.rd_addr = (sl != tail_ff) ? sl : head_ff;
               end
               default: ;
            endcase
         end
         S_INS_HEAD: begin
            if (blk < rd_entry.blk) begin
               mem_req.wr_addr     = p_ff;
               mem_req.wr_entry    = item_entry;
               mem_req.wr_entry_en = 1'b1;
               mem_req.wr_link.nxt = head_ff;
               mem_req.wr_next_en  = 1'b1;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = tail_ff;
            end
         end
         S_HEAD_PREV: begin
            mem_req.wr_addr     = head_ff;
            mem_req.wr_link.prv = p_ff;
            mem_req.wr_prev_en  = 1'b1;
         end
         S_INS_TAIL: begin
            if (blk >= rd_entry.blk) begin
               mem_req.wr_addr     = p_ff;
               mem_req.wr_entry    = item_entry;
               mem_req.wr_entry_en = 1'b1;
               mem_req.wr_link.prv = tail_ff;
               mem_req.wr_prev_en  = 1'b1;
            end else begin
               mem_req.rd_en   = (u_ff != tail_ff);
               mem_req.rd_addr = unext_ff;
            end
         end
         S_LINK_TAIL: begin
            mem_req.wr_addr     = tail_ff;
            mem_req.wr_link.nxt = p_ff;
            mem_req.wr_next_en  = 1'b1;
         end
         S_INS_WALK: begin
            if (ins_hit) begin
               mem_req.wr_addr     = p_ff;
               mem_req.wr_entry    = item_entry;
               mem_req.wr_entry_en = 1'b1;
               mem_req.wr_link     = '{nxt: unext_ff, prv: u_ff};
               mem_req.wr_next_en  = 1'b1;
               mem_req.wr_prev_en  = 1'b1;
            end else begin
               mem_req.rd_en   = walk_go;
               mem_req.rd_addr = rd_link.nxt;
            end
         end
         S_INS_LU: begin
            mem_req.wr_addr     = u_ff;
            mem_req.wr_link.nxt = p_ff;
            mem_req.wr_next_en  = 1'b1;
         end
         S_INS_LV: begin
            mem_req.wr_addr     = unext_ff;
            mem_req.wr_link.prv = p_ff;
            mem_req.wr_prev_en  = 1'b1;
         end
         S_FIND: begin
            mem_req.rd_en   = !key_hit && (n_inc < count_ff);
            mem_req.rd_addr = rd_link.nxt;
         end
         S_MRG_TAIL: begin
            mem_req.rd_en   = !(key_hit && (rd_entry.merges < merge_limit)) &&
                              (head_ff != tail_ff);
            mem_req.rd_addr = head_ff;
         end
         S_MRG_HEAD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = rd_link.nxt;
         end
         S_MRG_WALK: begin
            mem_req.rd_en   = !mrg_key && walk_go;
            mem_req.rd_addr = rd_link.nxt;
         end
         S_RM_CHK: begin
            if ((count_ff > 6'd1) && (sl != head_ff) && (sl != tail_ff)) begin
               mem_req.wr_addr     = rd_link.prv;
               mem_req.wr_link.nxt = rd_link.nxt;
               mem_req.wr_next_en  = 1'b1;
            end
         end
         S_RM_W2: begin
            mem_req.wr_addr     = lnk_ff.nxt;
            mem_req.wr_link.prv = lnk_ff.prv;
            mem_req.wr_prev_en  = 1'b1;
         end
         S_NX_LINK: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = rd_link.nxt;
         end
         S_UPD: begin
            mem_req.wr_addr         = sl;
            mem_req.wr_entry.merges = item_ff.merge_count_in;
            mem_req.wr_merges_en    = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  item_ff  <= req_data;
                  p_ff     <= free_slot;
                  state_ff <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               state_ff <= S_RESP;
               res_ff   <= res_bad(sbrq_pkg::STAT_NONE);
               n_ff     <= '0;
               unique case (item_ff.kind)
                  sbrq_pkg::KIND_APPEND, sbrq_pkg::KIND_INSERT: begin
                     if (full) begin
                        res_ff <= res_bad(sbrq_pkg::STAT_FULL);
                     end else if (count_ff == '0) begin
                        used_ff[p_ff] <= 1'b1;
                        count_ff      <= count_ff + 1'b1;
                        head_ff       <= p_ff;
                        tail_ff       <= p_ff;
                        res_ff        <= res_ok(p_ff, item_entry);
                     end else if (item_ff.kind == sbrq_pkg::KIND_INSERT) begin
                        state_ff <= S_INS_HEAD;
                     end else begin
                        state_ff <= S_LINK_TAIL;
                     end
                  end
                  sbrq_pkg::KIND_FIND: begin
                     u_ff <= head_ff;
                     if (count_ff != '0) state_ff <= S_FIND;
                  end
                  sbrq_pkg::KIND_MERGE: begin
                     if (count_ff != '0) state_ff <= S_MRG_TAIL;
                  end
                  sbrq_pkg::KIND_REMOVE: begin
                     if (sl_ok) state_ff <= S_RM_CHK;
                  end
                  sbrq_pkg::KIND_UPDATE: begin
                     if (sl_ok) state_ff <= S_UPD;
                  end
                  sbrq_pkg::KIND_NEXT: begin
                     if (sl_ok && (sl != tail_ff)) begin
                        state_ff <= S_NX_LINK;
                     end else if (sl_ok && (sl != head_ff)) begin
                        u_ff     <= head_ff;
                        state_ff <= S_NX_DATA;
                     end
                  end
                  default: ;
               endcase
            end
            S_INS_HEAD: begin
               u_ff     <= head_ff;
               ue_ff    <= rd_entry;
               unext_ff <= rd_link.nxt;
               state_ff <= (blk < rd_entry.blk) ? S_HEAD_PREV : S_INS_TAIL;
            end
            S_HEAD_PREV: begin
               used_ff[p_ff] <= 1'b1;
               count_ff      <= count_ff + 1'b1;
               head_ff       <= p_ff;
               res_ff        <= res_ok(p_ff, item_entry);
               state_ff      <= S_RESP;
            end
            S_INS_TAIL: begin
               if (blk >= rd_entry.blk) begin
                  state_ff <= S_LINK_TAIL;
               end else if (u_ff != tail_ff) begin
                  state_ff <= S_INS_WALK;
               end else begin
                  res_ff   <= res_bad(sbrq_pkg::STAT_NONE);
                  state_ff <= S_RESP;
               end
            end
            S_LINK_TAIL: begin
               used_ff[p_ff] <= 1'b1;
               count_ff      <= count_ff + 1'b1;
               tail_ff       <= p_ff;
               res_ff        <= res_ok(p_ff, item_entry);
               state_ff      <= S_RESP;
            end
            S_INS_WALK: begin
               // read data here belongs to the successor of u
               if (ins_hit) begin
                  state_ff <= S_INS_LU;
               end else begin
                  u_ff     <= unext_ff;
                  ue_ff    <= rd_entry;
                  unext_ff <= rd_link.nxt;
                  n_ff     <= n_inc;
                  if (!walk_go) begin
                     res_ff   <= res_bad(sbrq_pkg::STAT_NONE);
                     state_ff <= S_RESP;
                  end
               end
            end
            S_INS_LU: begin
               state_ff <= S_INS_LV;
            end
            S_INS_LV: begin
               used_ff[p_ff] <= 1'b1;
               count_ff      <= count_ff + 1'b1;
               res_ff        <= res_ok(p_ff, item_entry);
               state_ff      <= S_RESP;
            end
            S_FIND: begin
               if (key_hit) begin
                  res_ff   <= res_ok(u_ff, rd_entry);
                  state_ff <= S_RESP;
               end else if (n_inc < count_ff) begin
                  u_ff <= rd_link.nxt;
                  n_ff <= n_inc;
               end else begin
                  res_ff   <= res_bad(sbrq_pkg::STAT_NONE);
                  state_ff <= S_RESP;
               end
            end
            S_MRG_TAIL: begin
               if (key_hit && (rd_entry.merges < merge_limit)) begin
                  res_ff   <= res_ok(tail_ff, rd_entry);
                  state_ff <= S_RESP;
               end else if (head_ff != tail_ff) begin
                  u_ff     <= head_ff;
                  state_ff <= S_MRG_HEAD;
               end else begin
                  res_ff   <= res_bad(sbrq_pkg::STAT_NONE);
                  state_ff <= S_RESP;
               end
            end
            S_MRG_HEAD: begin
               ue_ff    <= rd_entry;
               unext_ff <= rd_link.nxt;
               state_ff <= S_MRG_WALK;
            end
            S_MRG_WALK: begin
               if (mrg_key) begin
                  res_ff   <= mrg_ok ? res_ok(u_ff, ue_ff) : res_bad(sbrq_pkg::STAT_NONE);
                  state_ff <= S_RESP;
               end else begin
                  u_ff     <= unext_ff;
                  ue_ff    <= rd_entry;
                  unext_ff <= rd_link.nxt;
                  n_ff     <= n_inc;
                  if (!walk_go) begin
                     res_ff   <= res_bad(sbrq_pkg::STAT_NONE);
                     state_ff <= S_RESP;
                  end
               end
            end
            S_RM_CHK: begin
               lnk_ff <= rd_link;
               res_ff <= res_ok(sl, rd_entry);
               if (count_ff <= 6'd1) begin
                  head_ff <= '0;
                  tail_ff <= '0;
               end else if (sl == head_ff) begin
                  head_ff <= rd_link.nxt;
               end else if (sl == tail_ff) begin
                  tail_ff <= rd_link.prv;
               end
               if ((count_ff > 6'd1) && (sl != head_ff) && (sl != tail_ff)) begin
                  state_ff <= S_RM_W2;
               end else begin
                  used_ff[sl] <= 1'b0;
                  count_ff    <= count_ff - 1'b1;
                  state_ff    <= S_RESP;
               end
            end
            S_RM_W2: begin
               used_ff[sl] <= 1'b0;
               count_ff    <= count_ff - 1'b1;
               state_ff    <= S_RESP;
            end
            S_NX_LINK: begin
               u_ff     <= rd_link.nxt;
               state_ff <= S_NX_DATA;
            end
            S_NX_DATA: begin
               res_ff   <= res_ok(u_ff, rd_entry);
               state_ff <= S_RESP;
            end
            S_UPD: begin
               res_ff   <= res_ok(sl, '{blk: rd_entry.blk, op: rd_entry.op,
                                        merges: item_ff.merge_count_in});
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (res_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== src/sorted_block_request_queue_unit.sv =====
// -----------------------------------------------------------------------------
// Sorted block request queue unit
// Linked request table with ordered insert, searches and circular next.
// -----------------------------------------------------------------------------
// Usage:
//   req_* carries one request word (kind, block, op, merge count, slot);
//   rsp_* returns exactly one result word per request; csr_* writes the
//   merge limit and is always ready; write it only while the unit is idle.
// Operation:
//   One request is in flight at a time. Find, find-mergeable and
//   mid-order insert walk the linked order with one store read per
//   cycle, bounded by the single read port of the entry store.
// Reset:
//   Synchronous; the table empties at once (slot valid bits cleared),
//   the merge limit returns to 10. No clearing pass.
// Stall:
//   A result waits in the output register while rsp_ready is low; the
//   next request is taken meanwhile and stops at its own result.
// -----------------------------------------------------------------------------
module sorted_block_request_queue_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sbrq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sbrq_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);

   logic [7:0]            merge_limit_ff;
   logic                  rsp_valid_ff;
   sbrq_pkg::rsp_type     rsp_data_ff;
   logic                  res_valid, res_ready;
   sbrq_pkg::rsp_type     res_data;
   sbrq_pkg::mem_req_type mem_req;
   sbrq_pkg::entry_type   rd_entry;
   sbrq_pkg::link_type    rd_link;

   assign csr_ready = 1'b1;
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_limit_ff <= sbrq_pkg::MERGE_LIMIT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) merge_limit_ff <= csr_data;
         if (res_ready) begin
            rsp_valid_ff <= res_valid;
            if (res_valid) rsp_data_ff <= res_data;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   sbrq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .merge_limit (merge_limit_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_data    (res_data),
      .mem_req     (mem_req),
      .rd_entry    (rd_entry),
      .rd_link     (rd_link)
   );

   sbrq_store u_store (
      .clock    (clock),
      .mem_req  (mem_req),
      .rd_entry (rd_entry),
      .rd_link  (rd_link)
   );

endmodule

// ===== src/sbrq_checker.sv =====
// -----------------------------------------------------------------------------
// Sorted block request queue: port checker
// Port-level assertions, bound to the top level.
// -----------------------------------------------------------------------------
`include "sorted_block_request_queue_unit_defines.svh"

module sbrq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sbrq_pkg::rsp_type rsp_data
);

   `SBRQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result word dropped or changed while stalled")
   `SBRQ_ASSERT_SAME(a_empty_flag, clock, reset, rsp_valid, rsp_data.is_empty == (rsp_data.entry_count == '0), "empty flag disagrees with entry count")
   `SBRQ_ASSERT_SAME(a_fail_zero, clock, reset, rsp_valid && (rsp_data.status != sbrq_pkg::STAT_OK), (rsp_data.slot_out == '0) && (rsp_data.found_block == '0) && (rsp_data.found_op == '0) && (rsp_data.found_merge_count == '0), "failed result carries entry data")
   `SBRQ_ASSERT_SAME(a_count_max, clock, reset, rsp_valid, rsp_data.entry_count <= sbrq_pkg::CNT_W'(sbrq_pkg::SLOTS), "entry count beyond table size")
   `SBRQ_ASSERT_NEXT(a_one_inflight, clock, reset, req_valid && req_ready, !req_ready, "second request taken while one is in flight")

endmodule

bind sorted_block_request_queue_unit sbrq_checker u_sbrq_checker (.*);
